@@ src/khe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khe_pkg
// Shared types, key codes, result kinds and the fixed hotstring table of the
// keystroke hotstring expander.
// ----------------------------------------------------------------------------
package khe_pkg;

  // Default depth of the typed-character history.
  localparam int HISTORY_DEPTH = 16;

  // Table geometry. The table below is fixed, so these are not parameters.
  localparam int NUM_ENTRIES         = 4;
  localparam int MAX_TRIGGER_LEN     = 4;
  localparam int MAX_REPLACEMENT_LEN = 16;

  // Derived widths.
  localparam int CHAR_W = 7;
  localparam int EW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int KW     = (MAX_TRIGGER_LEN > 1) ? $clog2(MAX_TRIGGER_LEN) : 1;
  localparam int TLW    = $clog2(MAX_TRIGGER_LEN + 1);
  localparam int RLW    = $clog2(MAX_REPLACEMENT_LEN + 1);
  localparam int RW     = (MAX_REPLACEMENT_LEN > 1) ? $clog2(MAX_REPLACEMENT_LEN) : 1;
  localparam int EMW    = $clog2(MAX_TRIGGER_LEN + MAX_REPLACEMENT_LEN);

  // Key codes.
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_UPPER_A   = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z   = 8'h5A;
  localparam logic [7:0] KEY_DIGIT_0   = 8'h30;
  localparam logic [7:0] KEY_DIGIT_9   = 8'h39;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;

  // Result kinds.
  localparam logic [1:0] KIND_FORWARD   = 2'd0;
  localparam logic [1:0] KIND_BACKSPACE = 2'd1;
  localparam logic [1:0] KIND_CHAR      = 2'd2;

  // Trigger lengths: "brb", "omw", "ty", "idk".
  localparam logic [TLW-1:0] TRIG_LEN [NUM_ENTRIES] = '{
    TLW'(3), TLW'(3), TLW'(2), TLW'(3)
  };

  // Trigger text stored newest character first, so that position k lines up
  // with the history character k places back from the newest one.
  localparam logic [CHAR_W-1:0] TRIG_REV [NUM_ENTRIES][MAX_TRIGGER_LEN] = '{
    '{7'h62, 7'h72, 7'h62, 7'h00},   // b r b
    '{7'h77, 7'h6D, 7'h6F, 7'h00},   // w m o
    '{7'h79, 7'h74, 7'h00, 7'h00},   // y t
    '{7'h6B, 7'h64, 7'h69, 7'h00}    // k d i
  };

  // Replacement lengths.
  localparam logic [RLW-1:0] REPL_LEN [NUM_ENTRIES] = '{
    RLW'(13), RLW'(9), RLW'(9), RLW'(12)
  };

  // Replacement text as UTF-16 code units.
  localparam logic [15:0] REPL_TEXT [NUM_ENTRIES][MAX_REPLACEMENT_LEN] = '{
    // "be right back"
    '{16'h0062, 16'h0065, 16'h0020, 16'h0072, 16'h0069, 16'h0067, 16'h0068, 16'h0074,
      16'h0020, 16'h0062, 16'h0061, 16'h0063, 16'h006B, 16'h0000, 16'h0000, 16'h0000},
    // "on my way"
    '{16'h006F, 16'h006E, 16'h0020, 16'h006D, 16'h0079, 16'h0020, 16'h0077, 16'h0061,
      16'h0079, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    // "thank you"
    '{16'h0074, 16'h0068, 16'h0061, 16'h006E, 16'h006B, 16'h0020, 16'h0079, 16'h006F,
      16'h0075, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    // "I don't know"
    '{16'h0049, 16'h0020, 16'h0064, 16'h006F, 16'h006E, 16'h0027, 16'h0074, 16'h0020,
      16'h006B, 16'h006E, 16'h006F, 16'h0077, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // accept a letter or digit and write it to the history
    logic pop;         // accept a backspace press and drop the newest character
    logic rd_step;     // read the next history character back for matching
    logic match_eval;  // latch the matching entry and clear history on a hit
    logic emit_load;   // move the next expansion result into the output register
    logic fwd_load;    // move a forward result into the output register
  } khe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;     // the offered item is a letter or digit press
    logic is_pop;      // the offered item is a backspace press
    logic rd_last;     // the last history read is being issued
    logic hit;         // some trigger matches the history suffix
    logic emit_none;   // the matching entry expands to no results at all
    logic emit_last;   // the current expansion result is the final one
    logic out_free;    // the output register can take a result this cycle
  } khe_sts_t;

  // Number of backspaces sent for an entry.
  function automatic logic [EMW-1:0] bs_count(input logic [EW-1:0] e);
    return EMW'(TRIG_LEN[e]) - EMW'(1);
  endfunction

  // Number of replacement characters sent for an entry.
  function automatic logic [EMW-1:0] repl_count(input logic [EW-1:0] e);
    logic [RLW-1:0] len;
    len = REPL_LEN[e];
    if (len > RLW'(MAX_REPLACEMENT_LEN)) begin
      len = RLW'(MAX_REPLACEMENT_LEN);
    end
    return EMW'(len);
  endfunction

endpackage

@@ src/khe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khe_ctrl
// Controller state machine: sequences the history write, the read-back of the
// newest characters, the trigger match and the emission of results.
// ----------------------------------------------------------------------------
module khe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  khe_pkg::khe_sts_t sts,
  output khe_pkg::khe_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_MATCH = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FWD   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_push) begin
            cmd.push  = 1'b1;
            state_nxt = S_READ;
          end else begin
            cmd.pop   = sts.is_pop;
            state_nxt = S_FWD;
          end
        end
      end
      S_READ: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_MATCH;
      end
      S_MATCH: begin
        cmd.match_eval = 1'b1;
        if (!sts.hit) begin
          state_nxt = S_FWD;
        end else if (sts.emit_none) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FWD: begin
        if (sts.out_free) begin
          cmd.fwd_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/khe_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khe_dpath
// Datapath: key classification, circular history memory, read-back window,
// trigger comparison, expansion counter and the output register.
// ----------------------------------------------------------------------------
module khe_dpath #(
  parameter int HISTORY_DEPTH = khe_pkg::HISTORY_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_key_code,
  input  logic              in_key_down,
  input  logic              in_shift_held,
  input  khe_pkg::khe_cmd_t cmd,
  output khe_pkg::khe_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [15:0]       out_char,
  output logic              out_last_of_run
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int SW     = CW + 1;
  localparam int CHAR_W = khe_pkg::CHAR_W;
  localparam int KW     = khe_pkg::KW;
  localparam int EW     = khe_pkg::EW;
  localparam int EMW    = khe_pkg::EMW;
  localparam int RW     = khe_pkg::RW;
  localparam int NE     = khe_pkg::NUM_ENTRIES;
  localparam int MTL    = khe_pkg::MAX_TRIGGER_LEN;

  // Folds a sum below twice the depth back into the history range.
  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(HISTORY_DEPTH)) ? (s - SW'(HISTORY_DEPTH)) : s;
    return AW'(t);
  endfunction

  logic [CHAR_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CHAR_W-1:0] rd_data_r;
  logic [KW-1:0]     rd_k_r;
  logic [KW-1:0]     rd_k_d_r;
  logic              rd_cap_r;
  logic [CHAR_W-1:0] win_r [MTL];
  logic [EW-1:0]     match_e_r;
  logic [EMW-1:0]    emit_idx_r;
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [15:0]       out_char_r;
  logic              out_last_r;

  logic              is_letter;
  logic              is_digit;
  logic [CHAR_W-1:0] push_char;
  logic              hist_full;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     rd_sum;
  logic [NE-1:0]     hit_vec;
  logic [EW-1:0]     match_e;
  logic [EMW-1:0]    match_total;
  logic [EMW-1:0]    emit_bs;
  logic [EMW-1:0]    emit_total;
  logic [EMW-1:0]    emit_pos;
  logic [1:0]        emit_kind;
  logic [15:0]       emit_char;

  // Key classification; letters are folded to lower case unless shifted.
  assign is_letter = (in_key_code >= khe_pkg::KEY_UPPER_A) &&
                     (in_key_code <= khe_pkg::KEY_UPPER_Z);
  assign is_digit  = (in_key_code >= khe_pkg::KEY_DIGIT_0) &&
                     (in_key_code <= khe_pkg::KEY_DIGIT_9);
  assign push_char = (is_letter && !in_shift_held) ?
                     (in_key_code[CHAR_W-1:0] + khe_pkg::CASE_OFFSET) :
                     in_key_code[CHAR_W-1:0];

  assign sts.is_push = in_key_down && (is_letter || is_digit);
  assign sts.is_pop  = in_key_down && (in_key_code == khe_pkg::KEY_BACKSPACE);

  // Write address: a full history overwrites its oldest entry.
  assign hist_full = (count_r == CW'(HISTORY_DEPTH));
  assign head_inc  = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : (head_r + AW'(1));
  assign wr_addr   = hist_full ? head_r : wrap_idx(SW'(head_r) + SW'(count_r));

  // History pointer updates.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      if (hist_full) begin
        head_nxt = head_inc;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (cmd.pop && (count_r != '0)) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.match_eval && sts.hit) begin
      head_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Read address of the character rd_k places back from the newest one.
  assign rd_sum  = SW'(head_r) + SW'(count_r) - SW'(1) - SW'(rd_k_r);
  assign rd_addr = (SW'(rd_k_r) < SW'(count_r)) ? wrap_idx(rd_sum) : '0;

  // History memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_mem[wr_addr] <= push_char;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  // Read sequencing; each read's registered data is captured into the window in the cycle after the read is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_k_r   <= '0;
      rd_cap_r <= 1'b0;
    end else begin
      rd_cap_r <= cmd.rd_step;
      if (cmd.push) begin
        rd_k_r <= '0;
      end else if (cmd.rd_step) begin
        rd_k_r <= rd_k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k_d_r <= rd_k_r;
    if (rd_cap_r) begin
      win_r[rd_k_d_r] <= rd_data_r;
    end
  end

  assign sts.rd_last = (rd_k_r == KW'(MTL - 1));

  // Trigger comparison against the newest characters of the history.
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      hit_vec[e] = (khe_pkg::TRIG_LEN[e] != '0) &&
                   (CW'(khe_pkg::TRIG_LEN[e]) <= count_r);
      for (int k = 0; k < MTL; k++) begin
        if ((k < int'(khe_pkg::TRIG_LEN[e])) && (win_r[k] != khe_pkg::TRIG_REV[e][k])) begin
          hit_vec[e] = 1'b0;
        end
      end
    end
  end

  // Lowest matching index wins.
  always_comb begin
    match_e = '0;
    for (int e = NE - 1; e >= 0; e--) begin
      if (hit_vec[e]) begin
        match_e = EW'(e);
      end
    end
  end

  assign match_total   = khe_pkg::bs_count(match_e) + khe_pkg::repl_count(match_e);
  assign sts.hit       = (hit_vec != '0);
  assign sts.emit_none = (match_total == '0);

  // Expansion counter: backspaces first, then the replacement text.
  always_ff @(posedge clk) begin
    if (cmd.match_eval) begin
      match_e_r <= match_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.match_eval) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_load) begin
      emit_idx_r <= emit_idx_r + EMW'(1);
    end
  end

  assign emit_bs       = khe_pkg::bs_count(match_e_r);
  assign emit_total    = emit_bs + khe_pkg::repl_count(match_e_r);
  assign emit_pos      = emit_idx_r - emit_bs;
  assign sts.emit_last = (emit_idx_r == (emit_total - EMW'(1)));

  always_comb begin
    if (emit_idx_r < emit_bs) begin
      emit_kind = khe_pkg::KIND_BACKSPACE;
      emit_char = '0;
    end else begin
      emit_kind = khe_pkg::KIND_CHAR;
      emit_char = khe_pkg::REPL_TEXT[match_e_r][RW'(emit_pos)];
    end
  end

  // Output register; it frees up when its transfer completes.
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.fwd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_load) begin
      out_kind_r <= khe_pkg::KIND_FORWARD;
      out_char_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_load) begin
      out_kind_r <= emit_kind;
      out_char_r <= emit_char;
      out_last_r <= sts.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

@@ src/keystroke_hotstring_expander.sv @@
`timescale 1ns / 1ps
// A forwarded key goes from its transfer straight to the output register load; a letter or
// digit is first read back newest first, 4 reads through the single registered memory read
// port, then captured into the window, matched and loaded into the output register.
// A new key is taken only once every result of the last key is in the output register, so
// output stalls also hold the input; a match expands to at most 15 results.
// Reset empties the history at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// keystroke_hotstring_expander
// Expands typed abbreviations into replacement text: tracks recent letters and
// digits, detects a trigger suffix and emits backspaces plus replacement text.
// ----------------------------------------------------------------------------
module keystroke_hotstring_expander #(
  parameter int HISTORY_DEPTH = khe_pkg::HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_code,
  input  logic        in_key_down,
  input  logic        in_shift_held,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_char,
  output logic        out_last_of_run
);

  khe_pkg::khe_cmd_t cmd;
  khe_pkg::khe_sts_t sts;

  // Sequencing.
  khe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // History, matching and result generation.
  khe_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key_code     (in_key_code),
    .in_key_down     (in_key_down),
    .in_shift_held   (in_shift_held),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ dv/khe_action_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khe_action_checker
// Watches both channels of the hotstring expander. It keeps its own copy of
// the typed-character history and predicts the output actions of every
// accepted key event. Each accepted output is compared field by field.
// ----------------------------------------------------------------------------
module khe_action_checker
  import khe_pkg::*;
#(
  parameter int HIST_DEPTH = HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_key_code,
  input  logic        in_key_down,
  input  logic        in_shift_held,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_char,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending,
  output int          actions_checked,
  output int          expansions
);

  // One predicted output action.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ch;
    logic        last;
  } key_action_t;

  key_action_t       action_q [$];
  logic [CHAR_W-1:0] hist [HIST_DEPTH];
  int                hist_head  = 0;
  int                hist_count = 0;
  int                n_fail     = 0;
  int                n_checked  = 0;
  int                n_expand   = 0;

  // Updates the history for one key event and queues the actions it causes.
  function automatic void expand_key(input logic [7:0] code, input logic down,
                                     input logic shift);
    logic [CHAR_W-1:0] ch;
    logic              is_letter;
    logic              is_digit;
    logic              hit;
    int                len;
    int                n_rep;
    is_letter = (code >= KEY_UPPER_A) && (code <= KEY_UPPER_Z);
    is_digit  = (code >= KEY_DIGIT_0) && (code <= KEY_DIGIT_9);
    hit       = 1'b0;
    if (down && (is_letter || is_digit)) begin
      ch = code[CHAR_W-1:0];
      if (is_letter && !shift) begin
        ch = ch + CASE_OFFSET;
      end
      // Push the character; a full history loses its oldest entry.
      if (hist_count >= HIST_DEPTH) begin
        hist[hist_head] = ch;
        hist_head = (hist_head + 1) % HIST_DEPTH;
      end else begin
        hist[(hist_head + hist_count) % HIST_DEPTH] = ch;
        hist_count++;
      end
      // Scan the table in order; the first trigger that ends the history wins.
      for (int e = 0; e < NUM_ENTRIES && !hit; e++) begin
        len = int'(TRIG_LEN[e]);
        if (len == 0 || len > MAX_TRIGGER_LEN || len > hist_count) begin
          continue;
        end
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (hist[(hist_head + hist_count - 1 - k) % HIST_DEPTH] != TRIG_REV[e][k]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          n_rep = int'(REPL_LEN[e]);
          if (n_rep > MAX_REPLACEMENT_LEN) begin
            n_rep = MAX_REPLACEMENT_LEN;
          end
          for (int i = 0; i < len - 1; i++) begin
            action_q.push_back(key_action_t'{KIND_BACKSPACE, 16'h0000, 1'b0});
          end
          for (int i = 0; i < n_rep; i++) begin
            action_q.push_back(key_action_t'{KIND_CHAR, REPL_TEXT[e][i], 1'b0});
          end
          if (len - 1 + n_rep > 0) begin
            action_q[action_q.size() - 1].last = 1'b1;
          end
          hist_head  = 0;
          hist_count = 0;
          n_expand++;
        end
      end
    end else if (down && code == KEY_BACKSPACE && hist_count > 0) begin
      hist_count--;
    end
    // Anything that did not expand is forwarded as it is.
    if (!hit) begin
      action_q.push_back(key_action_t'{KIND_FORWARD, 16'h0000, 1'b1});
    end
  endfunction

  // Outputs are compared before the key of the same edge is predicted, since
  // an output always belongs to an older key event.
  always @(posedge clk) begin : monitor
    key_action_t want;
    if (!rst_n) begin
      hist_head  = 0;
      hist_count = 0;
      action_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (action_q.size() == 0) begin
          $error("unexpected output transfer: out_kind %0d out_char 0x%04h",
                 out_kind, out_char);
          n_fail++;
        end else begin
          want = action_q.pop_front();
          n_checked++;
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
            n_fail++;
          end
          if (out_char !== want.ch) begin
            $error("out_char: expected 0x%04h, actual 0x%04h", want.ch, out_char);
            n_fail++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %0b, actual %0b", want.last,
                   out_last_of_run);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expand_key(in_key_code, in_key_down, in_shift_held);
      end
    end
    fail_count      <= n_fail;
    pending         <= action_q.size();
    actions_checked <= n_checked;
    expansions      <= n_expand;
  end

endmodule

@@ dv/keystroke_hotstring_expander_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_hotstring_expander_tb
// Drives key events into the hotstring expander: a directed pass over the
// special keys and every trigger, then random typing that is mostly trigger
// words with noise around them. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module keystroke_hotstring_expander_tb;
  import khe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TOTAL_KEYS     = 260;
  localparam int PHASE_B_START  = 87;
  localparam int PHASE_C_START  = 174;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_key_code   = 8'h00;
  logic        in_key_down   = 1'b0;
  logic        in_shift_held = 1'b0;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_char;
  logic        out_last_of_run;

  int fail_count;
  int pending;
  int actions_checked;
  int expansions;
  int send_idle_pct = 8;
  int recv_idle_pct = 56;
  int keys_sent     = 0;
  int idle_cycles   = 0;

  string trig_words [NUM_ENTRIES] = '{"brb", "omw", "ty", "idk"};

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keystroke_hotstring_expander u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_code     (in_key_code),
    .in_key_down     (in_key_down),
    .in_shift_held   (in_shift_held),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

  khe_action_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_code     (in_key_code),
    .in_key_down     (in_key_down),
    .in_shift_held   (in_shift_held),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending),
    .actions_checked (actions_checked),
    .expansions      (expansions)
  );

  // Output stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one key event, with an optional idle gap, and waits for its transfer.
  // Valid stays high after the transfer unless the next call idles first.
  task automatic send_key(input logic [7:0] code, input logic down, input logic shift);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_key_code   <= code;
    in_key_down   <= down;
    in_shift_held <= shift;
    do @(posedge clk); while (!in_ready);
    keys_sent++;
  endtask

  // Types a lower-case word as key presses; letters go out as upper-case codes.
  task automatic type_text(input string s, input logic shift);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z") begin
        c = c - 8'h20;
      end
      send_key(c, 1'b1, shift);
    end
  endtask

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(KEY_UPPER_A, KEY_UPPER_Z));
    end
    return 8'($urandom_range(KEY_DIGIT_0, KEY_DIGIT_9));
  endfunction

  // Any event at all: special keys, letters, digits, releases, shift.
  task automatic send_noise();
    logic [7:0] code;
    case ($urandom_range(0, 4))
      0: begin
        code = KEY_BACKSPACE;
      end
      1, 2: begin
        code = rand_alnum();
      end
      default: begin
        code = 8'($urandom_range(0, 255));
      end
    endcase
    send_key(code, $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
  endtask

  // Types a trigger word, sometimes broken on purpose.
  task automatic send_word(input int e, input int mode);
    string      w;
    int         pos;
    logic [7:0] c;
    w   = trig_words[e];
    pos = $urandom_range(0, w.len() - 1);
    for (int i = 0; i < w.len(); i++) begin
      c = w[i] - 8'h20;
      if (mode == 3 && i == w.len() - 1) begin
        break;
      end
      if (mode == 2 && i == pos) begin
        // A typo corrected with backspace still completes the trigger.
        send_key(rand_alnum(), 1'b1, 1'b0);
        send_key(KEY_BACKSPACE, 1'b1, 1'b0);
      end
      send_key(c, 1'b1, mode == 1 && i == pos);
      if ($urandom_range(0, 4) == 0) begin
        send_key(c, 1'b0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass: non-press events, extreme codes, empty backspace, digits.
    send_key(KEY_UPPER_A + 8'd1, 1'b0, 1'b0);
    send_key(KEY_UPPER_A + 8'd1, 1'b0, 1'b1);
    send_key(8'h00, 1'b1, 1'b0);
    send_key(8'hFF, 1'b1, 1'b1);
    send_key(KEY_BACKSPACE, 1'b1, 1'b0);
    send_key(KEY_DIGIT_0, 1'b1, 1'b0);
    send_key(KEY_DIGIT_9, 1'b1, 1'b1);
    // Every trigger in table order.
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      type_text(trig_words[e], 1'b0);
    end
    // Shift held keeps the letters upper case, so nothing expands.
    type_text("ty", 1'b1);
    // A backspace pops the stray letter and the trigger still completes.
    type_text("tx", 1'b0);
    send_key(KEY_BACKSPACE, 1'b1, 1'b0);
    type_text("y", 1'b0);
    send_key(KEY_UPPER_A, 1'b1, 1'b0);
    send_key(KEY_UPPER_Z, 1'b1, 1'b1);

    // Random typing, mostly trigger words surrounded by noise.
    while (keys_sent < TOTAL_KEYS) begin
      if (keys_sent >= PHASE_C_START) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (keys_sent >= PHASE_B_START) begin
        send_idle_pct = 56;
        recv_idle_pct = 8;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          repeat ($urandom_range(0, 3)) send_key(rand_alnum(), 1'b1,
                                                 $urandom_range(0, 3) == 0);
          send_word($urandom_range(0, NUM_ENTRIES - 1), 0);
        end
        11, 12, 13: begin
          send_word($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(1, 3));
        end
        14: begin
          // Overflow the history with digits, then finish a trigger.
          repeat ($urandom_range(HISTORY_DEPTH, HISTORY_DEPTH + 4)) begin
            send_key(8'($urandom_range(KEY_DIGIT_0, KEY_DIGIT_9)), 1'b1, 1'b0);
          end
          send_word($urandom_range(0, NUM_ENTRIES - 1), 0);
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      endcase
    end

    // Drain every outstanding action, then allow for trailing output.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key events; checked %0d output actions from %0d expansions.",
             keys_sent, actions_checked, expansions);
    $display("Idle mixes covered: sender-light, receiver-light and back-to-back.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/khe_pkg.sv
src/khe_ctrl.sv
src/khe_dpath.sv
src/keystroke_hotstring_expander.sv
dv/khe_action_checker.sv
dv/keystroke_hotstring_expander_tb.sv
